// ===== sv/osm_pkg.sv =====
// Package for the order statistic multiset: sizes, codes and shared types.
`default_nettype none
package osm_pkg;

  localparam int CAPACITY   = 1024;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int GROUP_SIZE = 32;
  localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_RANK   = 3'd2;
  localparam logic [2:0] OP_KTH    = 3'd3;
  localparam logic [2:0] OP_PRED   = 3'd4;
  localparam logic [2:0] OP_SUCC   = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_GRP,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] operand;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] answer;
  } rsp_t;

  typedef struct packed {
    logic               capture;
    logic               ins_en;
    logic               rem_en;
    logic [2:0]         op;
    logic signed [31:0] key;
    logic [CNT_W-1:0]   count;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== sv/osm_cell.sv =====
// One storage cell of the sorted row: compare flags, selection and shift update.
`default_nettype none
module osm_cell (
  input  wire logic                          clk_i,
  input  wire osm_pkg::cell_ctl_t            ctl_i,
  input  wire logic [osm_pkg::IDX_W-1:0]     idx_i,
  input  wire logic signed [31:0]            left_val_i,
  input  wire logic                          left_le_i,
  input  wire logic signed [31:0]            right_val_i,
  input  wire logic                          right_lt_i,
  output logic signed [31:0]                 val_o,
  output logic                               lt_o,
  output logic                               le_o,
  output logic                               hit_o,
  output logic [31:0]                        ans_o
);

  logic signed [31:0] val_q;
  logic               occ_q, lt_q, le_q, eq_q, kth_q;
  logic               occ;
  logic               bnd_lt, bnd_le;
  logic [31:0]        idx_p1;

  assign occ    = osm_pkg::CNT_W'(idx_i) < ctl_i.count;
  assign idx_p1 = 32'(idx_i) + 32'd1;

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      occ_q <= occ;
      lt_q  <= occ && (val_q < ctl_i.key);
      le_q  <= occ && (val_q <= ctl_i.key);
      eq_q  <= occ && (val_q == ctl_i.key);
      kth_q <= occ && (ctl_i.key == $signed(idx_p1));
    end
  end

  // insert opens a gap at the first cell above the key; remove closes the one at the key
  always_ff @(posedge clk_i) begin
    if (ctl_i.ins_en && !le_q) begin
      val_q <= left_le_i ? ctl_i.key : left_val_i;
    end else if (ctl_i.rem_en && !lt_q) begin
      val_q <= right_val_i;
    end
  end

  assign bnd_lt = lt_q && !right_lt_i;
  assign bnd_le = occ_q && !le_q && left_le_i;

  always_comb begin
    hit_o = 1'b0;
    ans_o = '0;
    case (ctl_i.op)
      osm_pkg::OP_REMOVE: hit_o = eq_q;
      osm_pkg::OP_RANK: begin
        hit_o = bnd_lt;
        ans_o = bnd_lt ? idx_p1 : '0;
      end
      osm_pkg::OP_KTH: begin
        hit_o = kth_q;
        ans_o = kth_q ? val_q : '0;
      end
      osm_pkg::OP_PRED: begin
        hit_o = bnd_lt;
        ans_o = bnd_lt ? val_q : '0;
      end
      osm_pkg::OP_SUCC: begin
        hit_o = bnd_le;
        ans_o = bnd_le ? val_q : '0;
      end
      default: begin
        hit_o = 1'b0;
        ans_o = '0;
      end
    endcase
  end

  assign val_o = val_q;
  assign lt_o  = lt_q;
  assign le_o  = le_q;

endmodule
`default_nettype wire

// ===== sv/osm_reduce.sv =====
// Registered first level of the OR tree: one hit and answer word per group of cells.
`default_nettype none
module osm_reduce (
  input  wire logic                 clk_i,
  input  wire logic                 hit_i [osm_pkg::CAPACITY],
  input  wire logic [31:0]          ans_i [osm_pkg::CAPACITY],
  output logic                      grp_hit_o [osm_pkg::NUM_GROUPS],
  output logic [31:0]               grp_ans_o [osm_pkg::NUM_GROUPS]
);

  logic        grp_hit_d [osm_pkg::NUM_GROUPS];
  logic [31:0] grp_ans_d [osm_pkg::NUM_GROUPS];

  always_comb begin
    for (int g = 0; g < osm_pkg::NUM_GROUPS; g++) begin
      grp_hit_d[g] = 1'b0;
      grp_ans_d[g] = '0;
      for (int j = 0; j < osm_pkg::GROUP_SIZE; j++) begin
        if (g * osm_pkg::GROUP_SIZE + j < osm_pkg::CAPACITY) begin
          grp_hit_d[g] = grp_hit_d[g] | hit_i[g * osm_pkg::GROUP_SIZE + j];
          grp_ans_d[g] = grp_ans_d[g] | ans_i[g * osm_pkg::GROUP_SIZE + j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_hit_o <= grp_hit_d;
    grp_ans_o <= grp_ans_d;
  end

endmodule
`default_nettype wire

// ===== sv/order_statistic_multiset.sv =====
// Top level: sequencer, element count, row of cells and final answer select.
// The result strobe is registered and rises after the compare, group and final states have run.
// No new item is taken while busy; the next item is taken while the strobe shows.
// The steps are compare in all cells, registered group OR, final OR and shift.
// Reset clears the sequencer and the element count; cell contents need no clearing.
// The receiver cannot stall; the done strobe for every result is high for exactly one cycle.
`default_nettype none
module order_statistic_multiset (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire osm_pkg::req_t req_i,
  output logic               busy_o,
  output logic               done_o,
  output osm_pkg::rsp_t      rsp_o
);

  osm_pkg::state_e           state_q, state_d;
  logic [2:0]                op_q;
  logic signed [31:0]        key_q;
  logic [osm_pkg::CNT_W-1:0] count_q, count_d;
  logic                      done_q, done_d;
  osm_pkg::rsp_t             rsp_q, rsp_d;
  osm_pkg::cell_ctl_t        ctl;

  logic signed [31:0] val [osm_pkg::CAPACITY];
  logic               lt  [osm_pkg::CAPACITY];
  logic               le  [osm_pkg::CAPACITY];
  logic               hit [osm_pkg::CAPACITY];
  logic [31:0]        ans [osm_pkg::CAPACITY];

  logic        grp_hit [osm_pkg::NUM_GROUPS];
  logic [31:0] grp_ans [osm_pkg::NUM_GROUPS];
  logic        hit_any;
  logic [31:0] ans_any;
  logic        full;
  logic        accept;

  assign accept = start_i && (state_q == osm_pkg::S_IDLE);
  assign full   = count_q == osm_pkg::CNT_W'(osm_pkg::CAPACITY);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= req_i.op;
      key_q <= req_i.operand;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= osm_pkg::S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  always_comb begin
    hit_any = 1'b0;
    ans_any = '0;
    for (int g = 0; g < osm_pkg::NUM_GROUPS; g++) begin
      hit_any = hit_any | grp_hit[g];
      ans_any = ans_any | grp_ans[g];
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    done_d      = 1'b0;
    rsp_d       = rsp_q;
    ctl.capture = 1'b0;
    ctl.ins_en  = 1'b0;
    ctl.rem_en  = 1'b0;
    ctl.op      = op_q;
    ctl.key     = key_q;
    ctl.count   = count_q;
    unique case (state_q)
      osm_pkg::S_IDLE: begin
        if (accept) state_d = osm_pkg::S_CMP;
      end
      osm_pkg::S_CMP: begin
        ctl.capture = 1'b1;
        state_d     = osm_pkg::S_GRP;
      end
      osm_pkg::S_GRP: begin
        state_d = osm_pkg::S_FIN;
      end
      osm_pkg::S_FIN: begin
        state_d      = osm_pkg::S_IDLE;
        done_d       = 1'b1;
        rsp_d.status = osm_pkg::ST_OK;
        rsp_d.answer = '0;
        case (op_q) inside
          osm_pkg::OP_INSERT: begin
            if (full) begin
              rsp_d.status = osm_pkg::ST_FULL;
            end else begin
              ctl.ins_en = 1'b1;
              count_d    = count_q + osm_pkg::CNT_W'(1);
            end
          end
          osm_pkg::OP_REMOVE: begin
            if (hit_any) begin
              ctl.rem_en = 1'b1;
              count_d    = count_q - osm_pkg::CNT_W'(1);
            end else begin
              rsp_d.status = osm_pkg::ST_NOT_FOUND;
            end
          end
          osm_pkg::OP_RANK: rsp_d.answer = $signed(ans_any + 32'd1);
          osm_pkg::OP_KTH, osm_pkg::OP_PRED, osm_pkg::OP_SUCC: begin
            if (hit_any) rsp_d.answer = $signed(ans_any);
            else         rsp_d.status = osm_pkg::ST_NOT_FOUND;
          end
          default: rsp_d.status = osm_pkg::ST_OK;
        endcase
      end
      default: state_d = osm_pkg::S_IDLE;
    endcase
  end

  for (genvar i = 0; i < osm_pkg::CAPACITY; i++) begin : g_cell
    logic signed [31:0] left_val, right_val;
    logic               left_le, right_lt;

    if (i == 0) begin : g_first
      assign left_val = val[i];
      assign left_le  = 1'b1;
    end else begin : g_mid_l
      assign left_val = val[i-1];
      assign left_le  = le[i-1];
    end

    if (i == osm_pkg::CAPACITY - 1) begin : g_last
      assign right_val = val[i];
      assign right_lt  = 1'b0;
    end else begin : g_mid_r
      assign right_val = val[i+1];
      assign right_lt  = lt[i+1];
    end

    osm_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .idx_i       (osm_pkg::IDX_W'(i)),
      .left_val_i  (left_val),
      .left_le_i   (left_le),
      .right_val_i (right_val),
      .right_lt_i  (right_lt),
      .val_o       (val[i]),
      .lt_o        (lt[i]),
      .le_o        (le[i]),
      .hit_o       (hit[i]),
      .ans_o       (ans[i])
    );
  end

  osm_reduce u_reduce (
    .clk_i     (clk_i),
    .hit_i     (hit),
    .ans_i     (ans),
    .grp_hit_o (grp_hit),
    .grp_ans_o (grp_ans)
  );

  assign busy_o = state_q != osm_pkg::S_IDLE;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= osm_pkg::CNT_W'(osm_pkg::CAPACITY))
    else $error("element count above capacity");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("item taken but block not busy");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == osm_pkg::ST_FULL) |-> full)
    else $error("full status with room left");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |=> $stable(count_q) || $past(state_q) == osm_pkg::S_FIN)
    else $error("element count changed outside final step");
`endif

endmodule
`default_nettype wire
